### sv/piecewise_linear_interpolator_unit_macros.svh
// Assertion macros for the piecewise linear interpolator.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH
// implication checked on every clock, masked in reset
`define PLI_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define PLI_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

### sv/pli_pkg.sv
// Types and constants shared by the interpolator modules.
package pli_pkg;
   localparam logic [1:0] CSR_MODE   = 2'd0;
   localparam logic [1:0] CSR_PERIOD = 2'd1;
   localparam logic [1:0] CSR_COUNT  = 2'd2;

   localparam logic [1:0] MODE_CONST = 2'd1;
   localparam logic [1:0] MODE_PER   = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_SAT   = 2'd2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE, S_RD0, S_RDL, S_SCAN, S_SEGA, S_SEGB, S_PICK, S_MUL,
      S_DIV, S_FIN, S_OUT
   } state_type;

   // phases of the segment evaluator
   typedef enum logic [1:0] {
      P_IDLE, P_LOAD, P_LOOP, P_DONE
   } phase_type;

   // operands of one segment evaluation
   typedef struct packed {
      logic signed [33:0] x1;
      logic signed [33:0] y1;
      logic signed [33:0] x2;
      logic signed [33:0] y2;
      logic signed [33:0] q;
   } seg_type;
endpackage

### sv/pli_div.sv
// Segment evaluator: 34x34 multiply then restoring divide, one bit a cycle.
module pli_div import pli_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  seg_type            seg,
   output logic               done,
   output logic signed [31:0] value,
   output logic               sat
);
   localparam int NB = 69;   // product magnitude bits
   phase_type   phase_ff, phase_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [33:0] ua_ff, ub_ff, ud_ff;
   logic        neg_ff, zero_ff;
   logic signed [33:0] y1_ff;
   logic [68:0] prod_ff;
   logic [34:0] rem_ff;
   logic [68:0] quo_ff;
   logic signed [33:0] dy, dq, dd;
   logic [35:0] rsh;
   logic [34:0] rnext;
   logic [40:0] qcl;
   logic signed [42:0] r;

   assign dy = seg.y2 - seg.y1;
   assign dq = seg.q - seg.x1;
   assign dd = seg.x2 - seg.x1;
   assign rsh = {rem_ff, prod_ff[cnt_ff]};
   assign rnext = (rsh >= {2'b0, ud_ff}) ? 35'(rsh - {2'b0, ud_ff}) : rsh[34:0];

   always_comb begin
      phase_in = phase_ff;
      cnt_in = cnt_ff;
      done = 1'b0;
      unique case (phase_ff)
         P_IDLE: if (start) phase_in = P_LOAD;
         P_LOAD: begin
            phase_in = P_LOOP;
            cnt_in = 7'(NB - 1);
         end
         P_LOOP: begin
            if (zero_ff || cnt_ff == 7'd0) phase_in = P_DONE;
            else cnt_in = cnt_ff - 7'd1;
         end
         P_DONE: begin
            done = 1'b1;
            phase_in = P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         cnt_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff <= cnt_in;
      end
      if (phase_ff == P_IDLE && start) begin
         ua_ff <= dy[33] ? 34'(-dy) : dy;
         ub_ff <= dq[33] ? 34'(-dq) : dq;
         ud_ff <= dd[33] ? 34'(-dd) : dd;
         neg_ff <= dy[33] ^ dq[33] ^ dd[33];
         zero_ff <= (dd == 0);
         y1_ff <= seg.y1;
      end
      if (phase_ff == P_LOAD) begin
         prod_ff <= {35'b0, ua_ff} * {35'b0, ub_ff};
         rem_ff <= '0;
         quo_ff <= '0;
      end
      if (phase_ff == P_LOOP && !zero_ff) begin
         rem_ff <= rnext;
         quo_ff[cnt_ff] <= (rsh >= {2'b0, ud_ff});
      end
   end

   // clamp quotient, apply sign, saturate
   always_comb begin
      qcl = (quo_ff > 69'(41'h100_0000_0000)) ? 41'h100_0000_0000 : quo_ff[40:0];
      if (zero_ff) r = 43'(y1_ff);
      else r = neg_ff ? 43'(y1_ff) - 43'(qcl) : 43'(y1_ff) + 43'(qcl);
      sat = (r > 43'sd2147483647) || (r < -43'sd2147483648);
      if (r > 43'sd2147483647) value = 32'sh7fffffff;
      else if (r < -43'sd2147483648) value = 32'sh80000000;
      else value = r[31:0];
   end
endmodule

### sv/piecewise_linear_interpolator_unit.sv
// Top level of the piecewise linear interpolator.
// channel | dir | tdata fields (low first)                | tuser
// req     | in  | index[3:0] query_x[35:4] point_y[67:36] | op
// rsp     | out | value[31:0] status[33:32]               | -
// csr     | in  | index, data                             | -
// A load goes straight from idle to the result. An evaluate reads both end
// points, scans the breakpoint memory one entry a cycle (n entries), then
// runs the segment unit, whose divide loop takes 69 steps. A hit, a constant
// end or a single point skips the segment unit; a zero-width segment skips the divide.
// Reset is synchronous and clears control and registers; the store is
// undefined until loaded. A stalled result holds the block.
module piecewise_linear_interpolator_unit import pli_pkg::*; #(
   parameter int MAX_POINTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // index, query_x, point_y, pad
   input  logic        req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // value, status, pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   // breakpoint memory: x and y side by side
   logic [63:0] mem [MAX_POINTS];
   logic [63:0] rd_ff;
   logic [AW-1:0] raddr;

   logic [1:0]  mode_ff;
   logic [30:0] period_ff;
   logic [4:0]  count_ff;
   state_type   st_ff, st_in;
   logic [CW-1:0] i_ff, i_in, n;
   logic signed [31:0] q_ff, x0_ff, y0_ff, xl_ff, yl_ff, px_ff, py_ff;
   logic signed [31:0] val_ff, val_in;
   logic [1:0]  sta_ff, sta_in;
   logic        hit_ff, found_ff;
   logic signed [31:0] kx1_ff, ky1_ff, kx2_ff, ky2_ff;
   seg_type     seg_ff, seg_in;
   logic        dstart, ddone, dsat;
   logic signed [31:0] dval;
   logic signed [31:0] rx, ry;
   logic        left, right;

   assign n = (int'(count_ff) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(count_ff);
   assign rx = rd_ff[31:0];
   assign ry = rd_ff[63:32];
   assign csr_ready = 1'b1;
   assign req_tready = (st_ff == S_IDLE);
   assign rsp_tvalid = (st_ff == S_OUT);
   assign rsp_tdata = {6'b0, sta_ff, val_ff};
   assign left = q_ff < x0_ff;
   assign right = q_ff > xl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
         period_ff <= '0;
         count_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == CSR_MODE) mode_ff <= csr_data[1:0];
         if (csr_index == CSR_PERIOD) period_ff <= csr_data[30:0];
         if (csr_index == CSR_COUNT) count_ff <= csr_data[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready && req_tuser == OP_LOAD &&
          int'(req_tdata[3:0]) < MAX_POINTS)
         mem[AW'(req_tdata[3:0])] <= {req_tdata[67:36], req_tdata[35:4]};
      rd_ff <= mem[raddr];
   end

   always_comb begin
      st_in = st_ff;
      i_in = i_ff;
      val_in = val_ff;
      sta_in = sta_ff;
      seg_in = seg_ff;
      dstart = 1'b0;
      raddr = '0;
      unique case (st_ff)
         S_IDLE: if (req_tvalid) begin
            val_in = '0; sta_in = ST_OK;
            if (req_tuser == OP_LOAD) st_in = S_OUT;
            else if (n == 0) begin sta_in = ST_EMPTY; st_in = S_OUT; end
            else st_in = S_RD0;
         end
         S_RD0: begin raddr = AW'(n - 1'b1); st_in = S_RDL; end
         S_RDL: begin raddr = '0; i_in = '0; st_in = S_SCAN; end
         S_SCAN: begin
            // entry i_ff is in rd_ff; request the next one
            raddr = AW'(i_ff + 1'b1);
            i_in = i_ff + 1'b1;
            // first exact hit supplies the value
            if (!hit_ff && rx == q_ff) val_in = ry;
            if (i_ff + 1'b1 == n) st_in = S_PICK;
         end
         S_PICK: begin
            st_in = S_MUL;
            if (n == 1) begin val_in = y0_ff; st_in = S_OUT; end
            else if (hit_ff) st_in = S_OUT;
            else if (left && mode_ff == MODE_CONST) begin
               val_in = y0_ff; st_in = S_OUT;
            end else if (right && mode_ff == MODE_CONST) begin
               val_in = yl_ff; st_in = S_OUT;
            end else if (left && mode_ff == MODE_PER)
               seg_in = '{34'(xl_ff) - 34'(period_ff), 34'(yl_ff), 34'(x0_ff),
                          34'(y0_ff), 34'(q_ff)};
            else if (right && mode_ff == MODE_PER)
               seg_in = '{34'(xl_ff), 34'(yl_ff), 34'(x0_ff) + 34'(period_ff),
                          34'(y0_ff), 34'(q_ff)};
            else
               seg_in = '{34'(kx1_ff), 34'(ky1_ff), 34'(kx2_ff), 34'(ky2_ff),
                          34'(q_ff)};
         end
         S_MUL: begin dstart = 1'b1; st_in = S_DIV; end
         S_DIV: if (ddone) begin
            val_in = dval; sta_in = dsat ? ST_SAT : ST_OK; st_in = S_OUT;
         end
         S_OUT: if (rsp_tready) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         i_ff <= '0;
         val_ff <= '0;
         sta_ff <= ST_OK;
      end else begin
         st_ff <= st_in;
         i_ff <= i_in;
         val_ff <= val_in;
         sta_ff <= sta_in;
      end
      seg_ff <= seg_in;
      if (st_ff == S_IDLE) begin
         q_ff <= req_tdata[35:4];
         hit_ff <= 1'b0;
         found_ff <= 1'b0;
      end
      if (st_ff == S_RDL) begin xl_ff <= rx; yl_ff <= ry; end
      // scan: hit search, first x above q, end segments for linear mode
      if (st_ff == S_SCAN) begin
         px_ff <= rx; py_ff <= ry;
         if (i_ff == 0) begin
            x0_ff <= rx; y0_ff <= ry;
         end
         if (!hit_ff && rx == q_ff) hit_ff <= 1'b1;
         if (i_ff == 1) begin
            if (q_ff < x0_ff || !found_ff) begin
               kx1_ff <= px_ff; ky1_ff <= py_ff; kx2_ff <= rx; ky2_ff <= ry;
            end
            if (q_ff >= x0_ff && q_ff < rx) found_ff <= 1'b1;
         end else if (i_ff > 1 && (!found_ff || right) && q_ff >= x0_ff) begin
            // past the right end the last segment is always kept
            kx1_ff <= px_ff; ky1_ff <= py_ff; kx2_ff <= rx; ky2_ff <= ry;
            if (q_ff < rx) found_ff <= 1'b1;
         end
      end
   end

   pli_div u_div (
      .clock(clock), .reset(reset), .start(dstart), .seg(seg_ff),
      .done(ddone), .value(dval), .sat(dsat)
   );
endmodule

### sv/pli_checker.sv
// Port-level checker for the interpolator, bound to the top level.
`include "piecewise_linear_interpolator_unit_macros.svh"
module pli_checker import pli_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   logic load_acc, rsp_stall;

   assign load_acc = req_tvalid && req_tready && req_tuser == OP_LOAD;
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   `PLI_ASSERT_IMP(a_no_accept_busy, clock, reset, rsp_tvalid, !req_tready, "accept while busy")
   `PLI_ASSERT_NXT(a_load_fast, clock, reset, load_acc, rsp_tvalid && rsp_tdata == 40'd0, "load")
   `PLI_ASSERT_IMP(a_status, clock, reset, rsp_tvalid, rsp_tdata[33:32] != 2'd3, "bad status")
   `PLI_ASSERT_NXT(a_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata), "dropped")
endmodule

bind piecewise_linear_interpolator_unit pli_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .req_tuser(req_tuser), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);

### tb/tb_piecewise_linear_interpolator_unit.sv
// Self-checking testbench for the piecewise linear interpolator unit.
`timescale 1ns / 1ps

// Scoreboard: own copy of table and registers, queue of expected results.
class interp_scoreboard;
   logic [31:0] abscissa [16];
   logic [31:0] ordinate [16];
   logic [1:0]  mode;
   logic [30:0] period;
   logic [4:0]  count;
   logic [31:0] want_value [$];
   logic [1:0]  want_status [$];
   int          errors;
   int          checked;
   int          saturated;
   int          empties;

   function new();
      mode = 0; period = 0; count = 0; errors = 0; checked = 0;
      saturated = 0; empties = 0;
      for (int i = 0; i < 16; i++) begin
         abscissa[i] = 0; ordinate[i] = 0;
      end
   endfunction

   function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
         pli_pkg::CSR_MODE:   mode = data[1:0];
         pli_pkg::CSR_PERIOD: period = data[30:0];
         pli_pkg::CSR_COUNT:  count = data[4:0];
         default: ;
      endcase
   endfunction

   // y1 + (y2-y1)*(q-x1)/(x2-x1), quotient magnitude clamped at 2^40
   function automatic longint seg_value(longint x1, longint y1, longint x2,
                                        longint y2, longint q, ref bit sat);
      logic [127:0] prod;
      logic [127:0] quo;
      longint       dy, dq, dx, r, mq;
      bit           neg;
      dx = x2 - x1;
      if (dx == 0) return y1;
      dy = y2 - y1;
      dq = q - x1;
      neg = (dy < 0) ^ (dq < 0) ^ (dx < 0);
      prod = 128'(dy < 0 ? -dy : dy) * 128'(dq < 0 ? -dq : dq);
      quo = prod / 128'(dx < 0 ? -dx : dx);
      if (quo > (128'd1 << 40)) quo = 128'd1 << 40;
      mq = longint'(quo[63:0]);
      r = neg ? y1 - mq : y1 + mq;
      if (r > 64'sd2147483647) begin
         sat = 1; r = 64'sd2147483647;
      end else if (r < -64'sd2147483648) begin
         sat = 1; r = -64'sd2147483648;
      end
      return r;
   endfunction

   function automatic longint ax(int i);
      return longint'($signed(abscissa[i]));
   endfunction

   function automatic longint oy(int i);
      return longint'($signed(ordinate[i]));
   endfunction

   // note an accepted request and queue its expected result
   function void note_request(logic op, logic [3:0] idx, logic [31:0] qx,
                              logic [31:0] py);
      int     n, k;
      longint q, p, x0, y0, xl, yl, v;
      bit     sat, hit;
      if (op == pli_pkg::OP_LOAD) begin
         abscissa[idx] = qx; ordinate[idx] = py;
         want_value.push_back(0); want_status.push_back(pli_pkg::ST_OK);
         return;
      end
      n = count > 16 ? 16 : count;
      if (n == 0) begin
         empties++;
         want_value.push_back(0); want_status.push_back(pli_pkg::ST_EMPTY);
         return;
      end
      q = longint'($signed(qx)); p = longint'(period);
      x0 = ax(0); y0 = oy(0); xl = ax(n - 1); yl = oy(n - 1);
      sat = 0; hit = 0; v = y0;
      if (n > 1) begin
         for (int i = 0; i < n; i++)
            if (!hit && ax(i) == q) begin
               v = oy(i); hit = 1;
            end
         if (!hit) begin
            if (q < x0) begin
               if (mode == pli_pkg::MODE_CONST) v = y0;
               else if (mode == pli_pkg::MODE_PER)
                  v = seg_value(xl - p, yl, x0, y0, q, sat);
               else v = seg_value(x0, y0, ax(1), oy(1), q, sat);
            end else if (q > xl) begin
               if (mode == pli_pkg::MODE_CONST) v = yl;
               else if (mode == pli_pkg::MODE_PER)
                  v = seg_value(xl, yl, x0 + p, y0, q, sat);
               else v = seg_value(ax(n - 2), oy(n - 2), xl, yl, q, sat);
            end else begin
               k = n - 1;
               for (int i = n - 1; i >= 1; i--)
                  if (q < ax(i)) k = i;
               v = seg_value(ax(k - 1), oy(k - 1), ax(k), oy(k), q, sat);
            end
         end
      end
      if (sat) saturated++;
      want_value.push_back(v[31:0]);
      want_status.push_back(sat ? pli_pkg::ST_SAT : pli_pkg::ST_OK);
   endfunction

   // compare one accepted result with the oldest expectation
   function void check_result(logic [31:0] value, logic [1:0] status);
      logic [31:0] ev;
      logic [1:0]  es;
      if (want_value.size() == 0) begin
         $error("unexpected result value %h status %0d", value, status);
         errors++;
         return;
      end
      ev = want_value.pop_front();
      es = want_status.pop_front();
      checked++;
      if (value !== ev) begin
         $error("value: expected %h, got %h", ev, value);
         errors++;
      end
      if (status !== es) begin
         $error("status: expected %0d, got %0d", es, status);
         errors++;
      end
   endfunction
endclass

module tb_piecewise_linear_interpolator_unit;
   import pli_pkg::*;

   localparam int LIMIT = 2000000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;   // index, query_x, point_y, pad
   logic        req_tuser = 0;    // op
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;       // value, status, pad
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   interp_scoreboard board = new();
   int  cycles = 0;
   bit  quiet = 0;      // no idling in the closing part
   bit  hold_off = 0;   // long receiver stall
   bit  held = 0;       // a long stall has been run
   int  sent = 0;
   logic [31:0] pts_x [16];
   int  used;           // slots loaded so far, reads stay below this

   piecewise_linear_interpolator_unit uut (.*);

   always #5 clock = ~clock;

   // cycle counter and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side: sample at rising edge, random stalls
   initial begin
      int gap;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_tready <= 0;
            repeat (400) @(negedge clock);
            hold_off = 0;
         end
         if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            rsp_tready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata[31:0], rsp_tdata[33:32]);

   task automatic send_item(logic op, logic [3:0] idx, logic [31:0] qx,
                            logic [31:0] py);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 12)) @(negedge clock);
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= {4'b0, py, qx, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(op, idx, qx, py);
      sent++;
      @(negedge clock);
      req_tvalid <= 0;
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic drain();
      while (board.want_value.size() != 0) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   // load n ascending breakpoints with random spacing; wide or narrow spread
   task automatic load_table(int n, bit wide);
      logic [31:0] x, y;
      longint      step;
      x = wide ? 32'h8000_0000 + $urandom_range(0, 32'h0100_0000)
               : $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      for (int i = 0; i < n; i++) begin
         y = $urandom();
         if ($urandom_range(0, 3) != 0) y = {{12{y[19]}}, y[19:0]};
         send_item(OP_LOAD, i[3:0], x, y);
         pts_x[i] = x;
         step = wide ? (64'h0FFF_FFFF / n) + $urandom_range(1, 32'h0010_0000)
                     : $urandom_range(1, 32'h0002_0000);
         x = x + step[31:0];
      end
      if (n > used) used = n;
   endtask

   function automatic logic [31:0] pick_query(int n);
      case ($urandom_range(0, 5))
         0: return pts_x[$urandom_range(0, n - 1)];
         1: return $urandom();
         2: return pts_x[0] - $urandom_range(1, 32'h0008_0000);
         3: return pts_x[n - 1] + $urandom_range(1, 32'h0008_0000);
         default: return pts_x[0] + $urandom_range(0, pts_x[n-1] - pts_x[0]);
      endcase
   endfunction

   initial begin
      int n, m, mode;
      used = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: empty table, extremes, all modes, single point, hits
      send_item(OP_EVAL, 4'hF, 32'h8000_0000, 32'hFFFF_FFFF);
      send_item(OP_LOAD, 4'd0, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(OP_LOAD, 4'd1, 32'h7FFF_FFFF, 32'h8000_0000);
      drain();
      write_csr(CSR_COUNT, 32'd1);
      send_item(OP_EVAL, 4'd0, 32'h1234_5678, 32'h0);
      drain();
      write_csr(CSR_COUNT, 32'd2);
      write_csr(CSR_PERIOD, 32'h7FFF_FFFF);
      for (int md = 0; md < 4; md++) begin
         drain();
         write_csr(CSR_MODE, md);
         send_item(OP_EVAL, 4'd0, 32'h8000_0000, 32'h0);
         send_item(OP_EVAL, 4'd0, 32'h7FFF_FFFF, 32'h0);
         send_item(OP_EVAL, 4'd0, 32'h0, 32'h0);
      end
      drain();
      // steep segment driving saturation both ways
      send_item(OP_LOAD, 4'd0, 32'h0, 32'h7FFF_0000);
      send_item(OP_LOAD, 4'd1, 32'h1, 32'h8000_0000);
      send_item(OP_EVAL, 4'd0, 32'h0000_0100, 32'h0);
      send_item(OP_EVAL, 4'd0, 32'hFFFF_FF00, 32'h0);
      // zero-width segment and over-range count
      send_item(OP_LOAD, 4'd1, 32'h0, 32'h5);
      send_item(OP_EVAL, 4'd0, 32'h10, 32'h0);
      used = 2;
      drain();
      load_table(16, 1);
      drain();
      write_csr(CSR_COUNT, 32'd31);
      write_csr(CSR_MODE, 0);
      send_item(OP_EVAL, 4'd0, 32'h7FFF_FFFF, 32'h0);
      send_item(OP_EVAL, 4'd0, pts_x[7], 32'h0);

      // random phases: fresh table, settings, then evaluates mixed with loads
      while (sent < 1000) begin
         drain();
         n = ($urandom_range(0, 4) == 0) ? 16 : $urandom_range(0, 6);
         mode = $urandom_range(0, 3);
         if (n > 0) load_table(n, $urandom_range(0, 1));
         drain();
         write_csr(CSR_COUNT, n);
         write_csr(CSR_MODE, mode);
         write_csr(CSR_PERIOD, $urandom_range(0, 1) ? $urandom() >> 1
                               : 32'h0100_0000 + $urandom_range(0, 32'h00FF_FFFF));
         m = $urandom_range(10, 40);
         for (int j = 0; j < m; j++) begin
            // long receiver stall while items keep coming
            if (j == 1 && sent > 500 && !hold_off &&
                (!held || $urandom_range(0, 5) == 0)) begin
               hold_off = 1;
               held = 1;
            end
            if (n == 0) send_item(OP_EVAL, 4'($urandom()), $urandom(), $urandom());
            else if ($urandom_range(0, 9) == 0)
               send_item(OP_LOAD, 4'd15, $urandom(), $urandom());
            else send_item(OP_EVAL, 4'($urandom()), pick_query(n), $urandom());
         end
         if (sent > 850) quiet = 1;
      end
      drain();
      $display("checked %0d results, %0d saturated, %0d on empty table",
               board.checked, board.saturated, board.empties);
      $display("all extrapolation modes, empty and over-range counts were exercised");
      if (board.errors == 0 && board.want_value.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule

### files.f
+incdir+sv
sv/pli_pkg.sv
sv/pli_div.sv
sv/piecewise_linear_interpolator_unit.sv
sv/pli_checker.sv
tb/tb_piecewise_linear_interpolator_unit.sv
